/* design/bfe_pkg.sv */
`timescale 1ns / 1ps

package bfe_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned BITS_W = 7;
  localparam int unsigned CNT_W  = 4;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_FIELD = 1'b1;

  localparam logic [1:0] KIND_SKIP   = 2'd0;
  localparam logic [1:0] KIND_STRING = 2'd1;
  localparam logic [1:0] KIND_INT    = 2'd2;

  localparam logic [1:0] STATUS_INT = 2'd0;
  localparam logic [1:0] STATUS_STR = 2'd1;
  localparam logic [1:0] STATUS_OVF = 2'd2;

  typedef struct packed {
    logic bit_reverse;
    logic byte_swap;
    logic signed_value;
  } fmt_ctrl_t;

  function automatic logic [WORD_W-1:0] bit_rev64(input logic [WORD_W-1:0] a);
    logic [WORD_W-1:0] b;
    for (int i = 0; i < WORD_W; i++) begin
      b[i] = a[WORD_W-1-i];
    end
    return b;
  endfunction

  function automatic logic [WORD_W-1:0] byte_rev64(input logic [WORD_W-1:0] a);
    logic [WORD_W-1:0] b;
    for (int i = 0; i < WORD_W / 8; i++) begin
      b[8*i +: 8] = a[WORD_W-8-8*i +: 8];
    end
    return b;
  endfunction

endpackage

/* design/bfe_int_format.sv */
`timescale 1ns / 1ps

module bfe_int_format (
  input  logic [bfe_pkg::WORD_W-1:0] raw,
  input  logic [bfe_pkg::BITS_W-1:0] nbits,
  input  bfe_pkg::fmt_ctrl_t         ctrl,
  output logic [bfe_pkg::WORD_W-1:0] value
);
  import bfe_pkg::*;

  logic [5:0]        pad;
  logic [7:0]        nbytes_w;
  logic [CNT_W-1:0]  nbytes;
  logic [2:0]        byte_pad;
  logic [WORD_W-1:0] s1;
  logic [WORD_W-1:0] s2;
  logic [WORD_W-1:0] ext;
  logic              top_bit;

  always_comb begin
    pad      = 6'(7'd64 - nbits);
    nbytes_w = (8'(nbits) + 8'd7) >> 3;
    nbytes   = CNT_W'(nbytes_w);
    byte_pad = 3'(4'd8 - nbytes);
    s1       = ctrl.bit_reverse ? (bit_rev64(raw) >> pad) : raw;
    s2       = ctrl.byte_swap ? (byte_rev64(s1) >> {byte_pad, 3'b000}) : s1;
    top_bit  = s2[6'(nbits - 7'd1)];
    ext      = {WORD_W{1'b1}} << nbits;
    value    = (ctrl.signed_value && top_bit) ? (s2 | ext) : s2;
  end

endmodule

/* design/bit_field_extractor_unit.sv */
`timescale 1ns / 1ps

// MSB-first bit unpacker. A load word appends data_byte to a BUFFER_BITS bit buffer; a
// field word takes the next 1..FIELD_MAX_BITS bits (fewer if fewer are held) as a skip,
// as MSB-aligned string bytes (one result per byte, last on the final one) or as an
// integer with optional bit reverse, byte reverse and sign extension. A byte that does
// not fit gives an overflow result. Each word passes the input register, then the result
// register if it gives a result; one word is accepted per cycle, except when such a word
// finds that register still held (result_ready low, or string bytes not all taken yet).
module bit_field_extractor_unit #(
  parameter int unsigned BUFFER_BITS    = 128,
  parameter int unsigned FIELD_MAX_BITS = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  logic                       func,
  input  logic [7:0]                 data_byte,
  input  logic [1:0]                 field_kind,
  input  logic                       bit_reverse,
  input  logic                       byte_swap,
  input  logic                       signed_value,
  input  logic [bfe_pkg::BITS_W-1:0] field_bits,
  output logic                       result_valid,
  input  logic                       result_ready,
  output logic [1:0]                 status,
  output logic [bfe_pkg::WORD_W-1:0] value,
  output logic [bfe_pkg::BITS_W-1:0] used_bits,
  output logic                       last
);
  import bfe_pkg::*;

  localparam int unsigned FW = $clog2(BUFFER_BITS + 1);

  logic [BUFFER_BITS-1:0] buffer;
  logic [FW-1:0]          fill;

  logic              s1_valid;
  logic              s1_func;
  logic [7:0]        s1_byte;
  logic [1:0]        s1_kind;
  fmt_ctrl_t         s1_ctrl;
  logic [BITS_W-1:0] s1_bits;

  logic [1:0]        r_status;
  logic [WORD_W-1:0] r_word;
  logic [BITS_W-1:0] r_used;
  logic [CNT_W-1:0]  r_cnt;

  logic [WORD_W-1:0]      top64;
  logic [BITS_W-1:0]      n_req;
  logic [FW-1:0]          n_req_w;
  logic [FW-1:0]          n_w;
  logic [BITS_W-1:0]      n;
  logic [5:0]             pad;
  logic [WORD_W-1:0]      raw;
  logic [WORD_W-1:0]      str_word;
  logic [WORD_W-1:0]      int_word;
  logic [7:0]             nbytes_w;
  logic                   is_load;
  logic                   ovf;
  logic                   take;
  logic                   has_result;
  logic                   r_done;
  logic                   s1_adv;
  logic [BUFFER_BITS-1:0] lmask;
  logic [BUFFER_BITS-1:0] lins;

  always_comb begin
    top64    = buffer[BUFFER_BITS-1 -: WORD_W];
    n_req    = (s1_bits > BITS_W'(FIELD_MAX_BITS)) ? BITS_W'(FIELD_MAX_BITS) : s1_bits;
    n_req_w  = FW'(n_req);
    n_w      = (fill < n_req_w) ? fill : n_req_w;
    n        = BITS_W'(n_w);
    pad      = 6'(7'd64 - n);
    raw      = top64 >> pad;
    str_word = top64 & ~({WORD_W{1'b1}} >> n);
    nbytes_w = (8'(n) + 8'd7) >> 3;
    is_load  = (s1_func == FUNC_LOAD);
    ovf      = (fill > FW'(BUFFER_BITS - 8));
    take     = !is_load && (fill != '0) && (s1_bits != '0);
    has_result = is_load ? ovf : (take && (s1_kind != KIND_SKIP));
    r_done   = result_valid && result_ready && (r_cnt == CNT_W'(1));
    s1_adv   = s1_valid && (!has_result || !result_valid || r_done);
    lmask    = {8'hff, {(BUFFER_BITS-8){1'b0}}} >> fill;
    lins     = {s1_byte, {(BUFFER_BITS-8){1'b0}}} >> fill;
  end

  assign item_ready = !s1_valid || s1_adv;

  bfe_int_format u_fmt (
    .raw   (raw),
    .nbits (n),
    .ctrl  (s1_ctrl),
    .value (int_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      fill         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        if (is_load && !ovf) begin
          fill <= fill + FW'(8);
        end else if (take) begin
          fill <= fill - n_w;
        end
      end
      if (s1_adv && has_result) begin
        result_valid <= 1'b1;
      end else if (r_done) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s1_func               <= func;
      s1_byte               <= data_byte;
      s1_kind               <= field_kind;
      s1_ctrl.bit_reverse   <= bit_reverse;
      s1_ctrl.byte_swap     <= byte_swap;
      s1_ctrl.signed_value  <= signed_value;
      s1_bits               <= field_bits;
    end
    if (s1_adv) begin
      if (is_load && !ovf) begin
        buffer <= (buffer & ~lmask) | lins;
      end else if (take) begin
        buffer <= buffer << n;
      end
    end
    if (s1_adv && has_result) begin
      if (is_load) begin
        r_status <= STATUS_OVF;
        r_word   <= {{(WORD_W-8){1'b0}}, s1_byte};
        r_used   <= '0;
        r_cnt    <= CNT_W'(1);
      end else if (s1_kind == KIND_STRING) begin
        r_status <= STATUS_STR;
        r_word   <= str_word;
        r_used   <= n;
        r_cnt    <= CNT_W'(nbytes_w);
      end else begin
        r_status <= STATUS_INT;
        r_word   <= int_word;
        r_used   <= n;
        r_cnt    <= CNT_W'(1);
      end
    end else if (result_valid && result_ready) begin
      r_cnt  <= r_cnt - CNT_W'(1);
      r_word <= r_word << 8;
    end
  end

  assign status    = r_status;
  assign value     = (r_status == STATUS_STR) ? {{(WORD_W-8){1'b0}}, r_word[WORD_W-1 -: 8]}
                                              : r_word;
  assign used_bits = r_used;
  assign last      = (r_cnt == CNT_W'(1));

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import bfe_pkg::*;

  localparam int BUF_BITS    = 128;
  localparam int MAX_FIELD   = 64;
  localparam int IDLE_LIMIT  = 4000;
  localparam int RAND_WORDS  = 500;
  localparam int PRED        = -1;
  localparam logic [1:0] KIND_ALT_INT = 2'd3;  // unused encoding, decodes as integer

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
    logic [1:0] kind;
    logic       brev;
    logic       le;
    logic       sgn;
    logic [6:0] nbits;
  } word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] value;
    logic [6:0]  used;
    logic        last;
  } result_t;

  typedef struct {
    word_t   w;
    int      reps;
    int      typed_n;
    result_t typed;
  } dir_row_t;

  localparam result_t NONE_RES = '{2'd0, 64'd0, 7'd0, 1'b0};
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_ready;
  logic       func = FUNC_LOAD;
  logic [7:0] data_byte = 8'd0;
  logic [1:0] field_kind = KIND_SKIP;
  logic       bit_reverse = 1'b0;
  logic       byte_swap = 1'b0;
  logic       signed_value = 1'b0;
  logic [6:0] field_bits = 7'd0;
  logic       result_valid;
  logic       result_ready = 1'b0;
  logic [1:0] status;
  logic [63:0] value;
  logic [6:0] used_bits;
  logic       last;

  logic [BUF_BITS-1:0] model_bits = '0;
  int          model_fill = 0;
  result_t     pending_results[$];
  int          errors = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  logic [15:0] stall_pat = 16'hFFFF;
  logic [15:0] stall_cyc = 16'd0;
  dir_row_t    directed_rows[25];

  bit_field_extractor_unit #(
    .BUFFER_BITS   (BUF_BITS),
    .FIELD_MAX_BITS(MAX_FIELD)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .func         (func),
    .data_byte    (data_byte),
    .field_kind   (field_kind),
    .bit_reverse  (bit_reverse),
    .byte_swap    (byte_swap),
    .signed_value (signed_value),
    .field_bits   (field_bits),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .value        (value),
    .used_bits    (used_bits),
    .last         (last)
  );

  always #6 clk = ~clk;

  function automatic void unpack_word(input word_t w, ref result_t res[$]);
    int n;
    int nbytes;
    logic [63:0] v;
    logic [63:0] t;
    if (w.func == FUNC_LOAD) begin
      if (model_fill + 8 > BUF_BITS) begin
        res.push_back('{STATUS_OVF, {56'd0, w.data_byte}, 7'd0, 1'b1});
        return;
      end
      model_bits[BUF_BITS-1-model_fill -: 8] = w.data_byte;
      model_fill += 8;
      return;
    end
    n = w.nbits;
    if (model_fill == 0 || n == 0) return;
    if (n > MAX_FIELD) n = MAX_FIELD;
    if (n > model_fill) n = model_fill;
    v = model_bits[BUF_BITS-1 -: 64] >> (64 - n);
    model_bits = model_bits << n;
    model_fill -= n;
    nbytes = (n + 7) / 8;
    if (w.kind == KIND_SKIP) return;
    if (w.kind == KIND_STRING) begin
      t = v << (64 - n);
      for (int i = 0; i < nbytes; i++) begin
        res.push_back('{STATUS_STR, {56'd0, t[63-8*i -: 8]}, 7'(n), i == nbytes - 1});
      end
      return;
    end
    if (w.brev) begin
      t = '0;
      for (int i = 0; i < n; i++) t[i] = v[n-1-i];
      v = t;
    end
    if (w.le) begin
      t = v;
      for (int i = 0; i < nbytes; i++) t[8*i +: 8] = v[8*(nbytes-1-i) +: 8];
      v = t;
    end
    if (w.sgn && n < 64 && v[n-1]) v = v | (ALL_ONES << n);
    res.push_back('{STATUS_INT, v, 7'(n), 1'b1});
  endfunction

  // drive one word with burst/gap idling, then record what it should produce
  task automatic feed_word(input word_t w, input int typed_n, input result_t typed);
    int gap;
    result_t got[$];
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 12);
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item_valid    <= 1'b1;
    func          <= w.func;
    data_byte     <= w.data_byte;
    field_kind    <= w.kind;
    bit_reverse   <= w.brev;
    byte_swap     <= w.le;
    signed_value  <= w.sgn;
    field_bits    <= w.nbits;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    unpack_word(w, got);
    if (typed_n == PRED) begin
      foreach (got[i]) pending_results.push_back(got[i]);
    end else if (typed_n == 1) begin
      pending_results.push_back(typed);
    end
  endtask

  always @(posedge clk) begin
    stall_cyc <= stall_cyc + 16'd1;
    if (stall_cyc[5:0] == 6'd0) begin
      case ($urandom_range(0, 3))
        0: stall_pat <= 16'hFFFF;
        1: stall_pat <= 16'($urandom) | 16'h0001;
        2: stall_pat <= 16'($urandom & $urandom & $urandom) | 16'h0001;
        default: stall_pat <= 16'($urandom) | 16'h8001;
      endcase
    end
    result_ready <= stall_pat[stall_cyc[3:0]];
  end

  always @(posedge clk) begin
    result_t exp_res;
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d value %h", status, value);
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        if (status !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, status);
          errors++;
        end
        if (value !== exp_res.value) begin
          $error("value: expected %h, got %h", exp_res.value, value);
          errors++;
        end
        if (used_bits !== exp_res.used) begin
          $error("used_bits: expected %0d, got %0d", exp_res.used, used_bits);
          errors++;
        end
        if (last !== exp_res.last) begin
          $error("last: expected %0d, got %0d", exp_res.last, last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    word_t w;
    int flood;
    int pick;
    directed_rows = '{
      '{'{FUNC_FIELD, 8'h00, KIND_INT,    1'b0, 1'b0, 1'b0, 7'd8},   1, 0,    NONE_RES},
      '{'{FUNC_LOAD,  8'h00, KIND_SKIP,   1'b0, 1'b0, 1'b0, 7'd0},   1, 0,    NONE_RES},
      '{'{FUNC_FIELD, 8'h00, KIND_INT,    1'b0, 1'b0, 1'b0, 7'd0},   1, 0,    NONE_RES},
      '{'{FUNC_FIELD, 8'h00, KIND_INT,    1'b0, 1'b0, 1'b0, 7'd8},   1, 1,
        '{STATUS_INT, 64'd0, 7'd8, 1'b1}},
      '{'{FUNC_LOAD,  8'hFF, KIND_SKIP,   1'b0, 1'b0, 1'b0, 7'd0},  16, 0,    NONE_RES},
      '{'{FUNC_LOAD,  8'h5A, KIND_SKIP,   1'b0, 1'b0, 1'b0, 7'd0},   1, 1,
        '{STATUS_OVF, 64'h5A, 7'd0, 1'b1}},
      '{'{FUNC_FIELD, 8'h00, KIND_INT,    1'b0, 1'b0, 1'b1, 7'd64},  1, 1,
        '{STATUS_INT, ALL_ONES, 7'd64, 1'b1}},
      '{'{FUNC_FIELD, 8'hFF, KIND_STRING, 1'b1, 1'b1, 1'b1, 7'd127}, 1, PRED, NONE_RES},
      '{'{FUNC_LOAD,  8'h80, KIND_SKIP,   1'b0, 1'b0, 1'b0, 7'd0},   1, 0,    NONE_RES},
      '{'{FUNC_FIELD, 8'h00, KIND_INT,    1'b0, 1'b0, 1'b1, 7'd1},   1, 1,
        '{STATUS_INT, ALL_ONES, 7'd1, 1'b1}},
      '{'{FUNC_FIELD, 8'h00, KIND_ALT_INT, 1'b1, 1'b0, 1'b0, 7'd7},  1, PRED, NONE_RES},
      '{'{FUNC_FIELD, 8'h00, KIND_STRING, 1'b0, 1'b0, 1'b0, 7'd8},   1, 0,    NONE_RES},
      '{'{FUNC_LOAD,  8'h12, KIND_SKIP,   1'b0, 1'b0, 1'b0, 7'd0},   1, 0,    NONE_RES},
      '{'{FUNC_LOAD,  8'h34, KIND_SKIP,   1'b0, 1'b0, 1'b0, 7'd0},   1, 0,    NONE_RES},
      '{'{FUNC_LOAD,  8'h56, KIND_SKIP,   1'b0, 1'b0, 1'b0, 7'd0},   1, 0,    NONE_RES},
      '{'{FUNC_FIELD, 8'h00, KIND_INT,    1'b0, 1'b1, 1'b0, 7'd20},  1, PRED, NONE_RES},
      '{'{FUNC_FIELD, 8'h00, KIND_SKIP,   1'b0, 1'b0, 1'b0, 7'd3},   1, 0,    NONE_RES},
      '{'{FUNC_FIELD, 8'h00, KIND_INT,    1'b1, 1'b1, 1'b1, 7'd21},  1, PRED, NONE_RES},
      '{'{FUNC_LOAD,  8'hC3, KIND_SKIP,   1'b0, 1'b0, 1'b0, 7'd0},   1, 0,    NONE_RES},
      '{'{FUNC_LOAD,  8'h3C, KIND_SKIP,   1'b0, 1'b0, 1'b0, 7'd0},   1, 0,    NONE_RES},
      '{'{FUNC_FIELD, 8'h00, KIND_STRING, 1'b0, 1'b0, 1'b0, 7'd13},  1, PRED, NONE_RES},
      '{'{FUNC_FIELD, 8'h00, KIND_INT,    1'b1, 1'b0, 1'b0, 7'd3},   1, PRED, NONE_RES},
      '{'{FUNC_LOAD,  8'h01, KIND_SKIP,   1'b0, 1'b0, 1'b0, 7'd0},   1, 0,    NONE_RES},
      '{'{FUNC_FIELD, 8'h00, KIND_INT,    1'b0, 1'b0, 1'b1, 7'd9},   1, PRED, NONE_RES},
      '{'{FUNC_FIELD, 8'h00, KIND_SKIP,   1'b0, 1'b0, 1'b0, 7'd64},  1, 0,    NONE_RES}
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      repeat (directed_rows[r].reps) begin
        feed_word(directed_rows[r].w, directed_rows[r].typed_n, directed_rows[r].typed);
      end
    end

    flood = 0;
    for (int k = 0; k < RAND_WORDS; k++) begin
      if (flood == 0 && $urandom_range(0, 49) == 0) flood = $urandom_range(10, 24);
      w.data_byte = 8'($urandom);
      w.brev      = 1'($urandom);
      w.le        = 1'($urandom);
      w.sgn       = 1'($urandom);
      pick = $urandom_range(0, 99);
      if (flood > 0) begin
        flood--;
        w.func = FUNC_LOAD;
      end else if (model_fill >= BUF_BITS - 8) begin
        w.func = (pick < 30) ? FUNC_LOAD : FUNC_FIELD;
      end else if (model_fill < 32) begin
        w.func = (pick < 75) ? FUNC_LOAD : FUNC_FIELD;
      end else begin
        w.func = (pick < 50) ? FUNC_LOAD : FUNC_FIELD;
      end
      case ($urandom_range(0, 19))
        0: w.nbits = 7'd0;
        1: w.nbits = 7'($urandom_range(65, 127));
        2: w.nbits = 7'd64;
        default: w.nbits = 7'($urandom_range(1, 64));
      endcase
      case ($urandom_range(0, 9))
        0:       w.kind = KIND_SKIP;
        1, 2, 3, 4: w.kind = KIND_STRING;
        9:       w.kind = KIND_ALT_INT;
        default: w.kind = KIND_INT;
      endcase
      feed_word(w, PRED, NONE_RES);
    end

    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
